// ----- hdl/rau_pkg.sv -----
// shared constants for the rational arithmetic unit
package rau_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

endpackage

// ----- hdl/rau_gcd.sv -----
// binary gcd reduction unit: one shift or subtract step per cycle
module rau_gcd #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] x_in,
  input  logic [W-1:0] y_in,
  output logic         done,
  output logic [W-1:0] g_out
);

  localparam int SW = $clog2(W + 1);

  logic [W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [SW-1:0] k_r, k_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W-1:0]  g_r, g_nxt;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    g_nxt = g_r;
    if (start) begin
      x_nxt = x_in;
      y_nxt = y_in;
      k_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r == '0) begin
        g_nxt = x_r << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (x_r == '0) begin
        g_nxt = y_r << k_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!x_r[0] && !y_r[0]) begin
        x_nxt = x_r >> 1;
        y_nxt = y_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!x_r[0]) begin
        x_nxt = x_r >> 1;
      end else if (!y_r[0]) begin
        y_nxt = y_r >> 1;
      end else if (x_r >= y_r) begin
        x_nxt = (x_r - y_r) >> 1;
      end else begin
        y_nxt = (y_r - x_r) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
  end

  assign done  = done_r;
  assign g_out = g_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("gcd done held");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("gcd done while busy");
  a_g_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && $past(x_r != '0 || y_r != '0) |-> g_r != '0) else $error("zero gcd");

endmodule

// ----- hdl/rational_arithmetic_unit_top.sv -----
// rational arithmetic unit top level: sequencer, shared datapath, result register
// Usage: present kind and the two fractions on in_* with in_valid; a beat is
// taken when in_valid is high and in_stall is low. in_stall stays high while
// an item is in work, including while its finished result waits to move into
// the output register. One result beat per item appears on out_* with out_valid.
// Steps: states M0 to M3 for the three cross products (one shared 33x33 magnitude
// multiplier, one product a cycle), a sign add state, a gcd start state, then
// the binary gcd unit on the 64-bit values at one step a cycle, then two
// divisions by the gcd that share one restoring divider, one bit a cycle, a
// range check state and a hand-off state. Error, zero-numerator and compare
// items skip the gcd and the divisions.
// Throughput: one item at a time; the next beat can be taken in the cycle after
// the hand-off into the output register.
// Reset clears the sequencer and the output valid; no clearing pass.
// While out_stall is high the result holds; the next item is taken and worked
// but waits at the hand-off until the held beat leaves.
module rational_arithmetic_unit_top #(
  parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_kind,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic [1:0]         out_status,
  output logic               out_less,
  output logic               out_equal,
  output logic               out_greater
);

  localparam int VW = VALUE_WIDTH;
  localparam int PW = 2 * VW;
  localparam int CW = $clog2(PW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0   = 4'd1;
  localparam logic [3:0] S_M1   = 4'd2;
  localparam logic [3:0] S_M2   = 4'd3;
  localparam logic [3:0] S_M3   = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_DIVN = 4'd7;
  localparam logic [3:0] S_DIVD = 4'd8;
  localparam logic [3:0] S_CHK  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;
  localparam logic [3:0] S_GWT  = 4'd11;

  logic [3:0] state_r, state_nxt;

  logic [2:0]    kind_r;
  logic [VW:0]   mag_r [4];   // an, ad, bn, bd magnitudes
  logic          neg_r [4];
  logic [PW-1:0] p_r [3];     // cross products
  logic          pn_r [3];
  logic [PW-1:0] num_r, den_r, g_r, q_r, rem_r, nq_r;
  logic          nneg_r, dneg_r;
  logic [CW-1:0] cnt_r;

  // result being built by the sequencer
  logic signed [31:0] w_num_r;
  logic [30:0]        w_den_r;
  logic [1:0]         w_st_r;
  logic               w_lt_r, w_eq_r, w_gt_r;

  logic signed [31:0] o_num_r;
  logic [30:0]        o_den_r;
  logic [1:0]         o_st_r;
  logic               o_lt_r, o_eq_r, o_gt_r, o_v_r;

  // operand extraction: low VW bits, magnitude and sign
  function automatic logic [VW:0] mag_of(input logic [31:0] raw);
    logic [VW-1:0] v;
    v = raw[VW-1:0];
    return v[VW-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
  endfunction

  // shared multiplier, operands chosen by state
  logic [VW:0]   ma, mb;
  logic          mna, mnb;
  logic [PW-1:0] mprod;
  always_comb begin
    ma = mag_r[0]; mb = mag_r[3]; mna = neg_r[0]; mnb = neg_r[3];
    case (state_r)
      S_M0: begin
        ma = mag_r[0]; mb = (kind_r == rau_pkg::KIND_MUL) ? mag_r[2] : mag_r[3];
        mna = neg_r[0]; mnb = (kind_r == rau_pkg::KIND_MUL) ? neg_r[2] : neg_r[3];
      end
      S_M1: begin
        ma = mag_r[1]; mb = mag_r[2]; mna = neg_r[1]; mnb = neg_r[2];
      end
      S_M2: begin
        ma = mag_r[1]; mb = (kind_r == rau_pkg::KIND_DIV) ? mag_r[2] : mag_r[3];
        mna = neg_r[1]; mnb = (kind_r == rau_pkg::KIND_DIV) ? neg_r[2] : neg_r[3];
      end
      default: ;
    endcase
  end
  assign mprod = PW'(ma * mb);

  // signed magnitude add of p0 and +/- p1
  logic          sub_neg1;
  logic [PW-1:0] sum_mag;
  logic          sum_neg;
  always_comb begin
    sub_neg1 = pn_r[1] ^ ((kind_r == rau_pkg::KIND_SUB) || (kind_r == rau_pkg::KIND_CMP));
    if (p_r[1] == '0) sub_neg1 = 1'b0;
    if (pn_r[0] == sub_neg1) begin
      sum_mag = p_r[0] + p_r[1];
      sum_neg = pn_r[0];
    end else if (p_r[0] >= p_r[1]) begin
      sum_mag = p_r[0] - p_r[1];
      sum_neg = pn_r[0];
    end else begin
      sum_mag = p_r[1] - p_r[0];
      sum_neg = sub_neg1;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  // numerator of the current item is zero
  logic num_zero;
  assign num_zero = (kind_r == rau_pkg::KIND_MUL || kind_r == rau_pkg::KIND_DIV) ?
                    (p_r[0] == '0) : (sum_mag == '0);

  logic          gcd_start, gcd_done;
  logic [PW-1:0] g_out;
  assign gcd_start = (state_r == S_GCD);

  rau_gcd #(.W(PW)) u_gcd (
    .clk(clk), .rst_n(rst_n), .start(gcd_start),
    .x_in(num_r), .y_in(den_r), .done(gcd_done), .g_out(g_out)
  );

  // restoring divider step
  logic [PW:0]   trial;
  logic [PW-1:0] rem_sh;
  assign rem_sh = {rem_r[PW-2:0], q_r[PW-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, g_r};

  logic [PW-1:0] limit, nlim;
  assign limit = (PW'(1) << (VW - 1)) - PW'(1);
  assign nlim  = (nneg_r != dneg_r) ? limit + PW'(1) : limit;

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_M0;
      S_M0:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_GCD;
      S_GCD:  state_nxt = S_GWT;
      S_GWT:  if (gcd_done) state_nxt = S_DIVN;
      S_DIVN: if (cnt_r == CW'(PW - 1)) state_nxt = S_DIVD;
      S_DIVD: if (cnt_r == CW'(PW - 1)) state_nxt = S_CHK;
      S_CHK:  state_nxt = S_OUT;
      S_OUT:  if (!o_v_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // early exits
    if (state_r == S_M0 && (mag_r[1] == '0 || mag_r[3] == '0 || kind_r > rau_pkg::KIND_CMP))
      state_nxt = S_OUT;
    if (state_r == S_SUM && (kind_r == rau_pkg::KIND_CMP || p_r[2] == '0 || num_zero))
      state_nxt = S_OUT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      o_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && (!o_v_r || !out_stall)) o_v_r <= 1'b1;
      else if (o_v_r && !out_stall) o_v_r <= 1'b0;
    end
    case (state_r)
      S_IDLE: if (accept) begin
        kind_r <= in_kind;
        mag_r[0] <= mag_of(in_a_num); neg_r[0] <= in_a_num[VW-1];
        mag_r[1] <= mag_of(in_a_den); neg_r[1] <= in_a_den[VW-1];
        mag_r[2] <= mag_of(in_b_num); neg_r[2] <= in_b_num[VW-1];
        mag_r[3] <= mag_of(in_b_den); neg_r[3] <= in_b_den[VW-1];
        w_num_r <= '0; w_den_r <= 31'd1; w_st_r <= rau_pkg::ST_OK;
        w_lt_r <= 1'b0; w_eq_r <= 1'b0; w_gt_r <= 1'b0;
      end
      S_M0: begin
        p_r[0] <= mprod; pn_r[0] <= (mprod != '0) && (mna != mnb);
        if (mag_r[1] == '0 || mag_r[3] == '0) w_st_r <= rau_pkg::ST_DIVZ;
      end
      S_M1: begin p_r[1] <= mprod; pn_r[1] <= (mprod != '0) && (mna != mnb); end
      S_M2: begin p_r[2] <= mprod; pn_r[2] <= (mprod != '0) && (mna != mnb); end
      S_M3: ;
      S_SUM: begin
        if (kind_r == rau_pkg::KIND_MUL || kind_r == rau_pkg::KIND_DIV) begin
          num_r <= p_r[0]; nneg_r <= pn_r[0];
        end else begin
          num_r <= sum_mag; nneg_r <= sum_neg;
        end
        den_r <= p_r[2]; dneg_r <= pn_r[2];
        if (kind_r == rau_pkg::KIND_CMP) begin
          if (sum_mag == '0) w_eq_r <= 1'b1;
          else if (sum_neg != (neg_r[1] != neg_r[3])) w_lt_r <= 1'b1;
          else w_gt_r <= 1'b1;
        end else if (p_r[2] == '0) begin
          w_st_r <= rau_pkg::ST_DIVZ;
        end
      end
      S_GWT: if (gcd_done) begin
        g_r <= g_out; q_r <= num_r; rem_r <= '0; cnt_r <= '0;
      end
      S_DIVN, S_DIVD: begin
        if (cnt_r == CW'(PW - 1)) begin
          cnt_r <= '0;
          rem_r <= '0;
          if (state_r == S_DIVN) begin
            nq_r <= {q_r[PW-2:0], !trial[PW]};
            q_r <= den_r;
          end else begin
            q_r <= {q_r[PW-2:0], !trial[PW]};
          end
        end else begin
          if (!trial[PW]) rem_r <= trial[PW-1:0];
          else rem_r <= rem_sh;
          q_r <= {q_r[PW-2:0], !trial[PW]};
          cnt_r <= cnt_r + 1'b1;
        end
      end
      S_CHK: begin
        if (nq_r > nlim || q_r > limit) begin
          w_st_r <= rau_pkg::ST_OVF;
        end else begin
          w_num_r <= (nneg_r != dneg_r) ? 32'(-nq_r) : 32'(nq_r);
          w_den_r <= 31'(q_r);
        end
      end
      S_OUT: if (!o_v_r || !out_stall) begin
        o_num_r <= w_num_r; o_den_r <= w_den_r; o_st_r <= w_st_r;
        o_lt_r <= w_lt_r; o_eq_r <= w_eq_r; o_gt_r <= w_gt_r;
      end
      default: ;
    endcase
  end

  assign out_valid   = o_v_r;
  assign out_res_num = o_num_r;
  assign out_res_den = o_den_r;
  assign out_status  = o_st_r;
  assign out_less    = o_lt_r;
  assign out_equal   = o_eq_r;
  assign out_greater = o_gt_r;

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r |-> $countones({o_lt_r, o_eq_r, o_gt_r}) <= 1) else $error("flags");
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r |-> o_den_r != '0) else $error("zero den");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && o_st_r != rau_pkg::ST_OK |-> o_num_r == '0 && o_den_r == 31'd1)
    else $error("error result");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("ready while busy");

endmodule

// ----- tb/sv/tb_rational_arithmetic_unit_top.sv -----
// self-checking testbench for the rational arithmetic unit top level
`timescale 1ns / 100ps

module tb_rational_arithmetic_unit_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct {
    logic [2:0] kind;
    logic signed [31:0] a_num, a_den, b_num, b_den;
  } frac_op_t;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0] den;
    logic [1:0] status;
    logic lt, eq, gt;
  } frac_res_t;

  // directed rows: known marks the ones with a result typed in
  typedef struct {
    frac_op_t op;
    bit known;
    frac_res_t res;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = rau_pkg::KIND_ADD;
  logic signed [31:0] in_a_num = '0, in_a_den = 32'sd1, in_b_num = '0, in_b_den = 32'sd1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic [1:0] out_status;
  logic out_less, out_equal, out_greater;

  frac_res_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  always #5 clk = ~clk;

  rational_arithmetic_unit_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_stall(out_stall), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_status(out_status), .out_less(out_less),
    .out_equal(out_equal), .out_greater(out_greater)
  );

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // exact rational result, computed in wide signed integers
  function automatic frac_res_t rational_result(frac_op_t op);
    frac_res_t r;
    logic signed [65:0] an, ad, bn, bd, num, den, diff;
    logic [65:0] nm, dm, g;
    logic neg;
    r.num = 0; r.den = 1; r.status = rau_pkg::ST_OK; r.lt = 0; r.eq = 0; r.gt = 0;
    an = op.a_num; ad = op.a_den; bn = op.b_num; bd = op.b_den;
    if (ad == 0 || bd == 0) begin
      r.status = rau_pkg::ST_DIVZ;
    end else if (op.kind == rau_pkg::KIND_CMP) begin
      diff = an * bd - bn * ad;
      if ((ad < 0) != (bd < 0)) diff = -diff;
      if (diff == 0) r.eq = 1;
      else if (diff < 0) r.lt = 1;
      else r.gt = 1;
    end else if (op.kind <= rau_pkg::KIND_DIV) begin
      case (op.kind)
        rau_pkg::KIND_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
        rau_pkg::KIND_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
        rau_pkg::KIND_MUL: begin num = an * bn; den = ad * bd; end
        default: begin num = an * bd; den = ad * bn; end
      endcase
      if (den == 0) begin
        r.status = rau_pkg::ST_DIVZ;
      end else if (num != 0) begin
        neg = (num < 0) != (den < 0);
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        g = gcd_of(nm[63:0], dm[63:0]);
        nm = nm / g;
        dm = dm / g;
        if (nm > (neg ? 66'h80000000 : 66'h7fffffff) || dm > 66'h7fffffff) begin
          r.status = rau_pkg::ST_OVF;
        end else begin
          r.num = neg ? -nm[31:0] : nm[31:0];
          r.den = dm[30:0];
        end
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 12) - 6;
      1: return 32'sh7fffffff - $urandom_range(0, 2);
      2: return 32'sh80000000 + $urandom_range(0, 2);
      3: return $urandom_range(1, 1000) * ($urandom_range(0, 1) ? 1 : -1);
      4: return $urandom & 32'h0000ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic frac_op_t rand_op();
    frac_op_t op;
    op.kind = 3'(($urandom_range(0, 19) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4));
    op.a_num = rand_value();
    op.a_den = rand_value();
    op.b_num = rand_value();
    op.b_den = rand_value();
    // keep most denominators nonzero so the arithmetic path is exercised
    if (op.a_den == 0 && $urandom_range(0, 3) != 0) op.a_den = 1;
    if (op.b_den == 0 && $urandom_range(0, 3) != 0) op.b_den = -1;
    return op;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_op(frac_op_t op, bit known, frac_res_t typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= op.kind;
    in_a_num <= op.a_num;
    in_a_den <= op.a_den;
    in_b_num <= op.b_num;
    in_b_den <= op.b_den;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(known ? typed : rational_result(op));
    @(negedge clk);
  endtask

  function automatic frac_res_t res_of(logic signed [31:0] n, logic [30:0] d, logic [1:0] s,
                                       logic lt, logic eq, logic gt);
    frac_res_t r;
    r.num = n; r.den = d; r.status = s; r.lt = lt; r.eq = eq; r.gt = gt;
    return r;
  endfunction

  function automatic frac_op_t op_of(logic [2:0] k, logic signed [31:0] an,
                                     logic signed [31:0] ad, logic signed [31:0] bn,
                                     logic signed [31:0] bd);
    frac_op_t op;
    op.kind = k; op.a_num = an; op.a_den = ad; op.b_num = bn; op.b_den = bd;
    return op;
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    frac_res_t exp_r;
    if (rst_n && (out_valid && !out_stall || in_valid && !in_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat num=%0d", out_res_num);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.num !== out_res_num || exp_r.den !== out_res_den ||
            exp_r.status !== out_status || exp_r.lt !== out_less ||
            exp_r.eq !== out_equal || exp_r.gt !== out_greater) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d st=%0d lt/eq/gt=%b%b%b got %0d/%0d st=%0d %b%b%b",
                     exp_r.num, exp_r.den, exp_r.status, exp_r.lt, exp_r.eq, exp_r.gt,
                     out_res_num, out_res_den, out_status, out_less, out_equal, out_greater);
        end
      end
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    directed_row_t rows[$];
    frac_res_t none;
    none = res_of(0, 1, rau_pkg::ST_OK, 0, 0, 0);
    rows.push_back('{op_of(rau_pkg::KIND_ADD, 1, 0, 1, 1), 1,
                     res_of(0, 1, rau_pkg::ST_DIVZ, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_CMP, 1, 1, 1, 0), 1,
                     res_of(0, 1, rau_pkg::ST_DIVZ, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_DIV, 3, 4, 0, 5), 1,
                     res_of(0, 1, rau_pkg::ST_DIVZ, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_ADD, 1, 2, 1, 3), 1,
                     res_of(5, 6, rau_pkg::ST_OK, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_SUB, 1, 2, 1, 2), 1,
                     res_of(0, 1, rau_pkg::ST_OK, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_MUL, 2, -4, 3, 1), 1,
                     res_of(-3, 2, rau_pkg::ST_OK, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_DIV, -1, 2, -1, 4), 1,
                     res_of(2, 1, rau_pkg::ST_OK, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_CMP, 1, 2, 2, 4), 1,
                     res_of(0, 1, rau_pkg::ST_OK, 0, 1, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_CMP, 1, -2, 1, 3), 1,
                     res_of(0, 1, rau_pkg::ST_OK, 1, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_CMP, 1, 2, 1, 3), 1,
                     res_of(0, 1, rau_pkg::ST_OK, 0, 0, 1)});
    rows.push_back('{op_of(3'd5, 1, 1, 1, 1), 1, none});
    rows.push_back('{op_of(3'd7, -1, -1, -1, -1), 1, none});
    rows.push_back('{op_of(rau_pkg::KIND_MUL, 32'sh7fffffff, 1, 2, 1), 1,
                     res_of(0, 1, rau_pkg::ST_OVF, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_MUL, 32'sh80000000, 1, 1, 1), 1,
                     res_of(32'sh80000000, 1, rau_pkg::ST_OK, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_DIV, 32'sh80000000, 1, -1, 1), 1,
                     res_of(0, 1, rau_pkg::ST_OVF, 0, 0, 0)});
    rows.push_back('{op_of(rau_pkg::KIND_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                           32'sh7fffffff), 0, none});
    rows.push_back('{op_of(rau_pkg::KIND_SUB, 32'sh80000000, 32'sh80000001, -1, -1), 0, none});
    rows.push_back('{op_of(rau_pkg::KIND_CMP, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                           32'sh80000000), 0, none});
    rows.push_back('{op_of(rau_pkg::KIND_DIV, 32'hffffffff, 32'h7fffffff, 32'h55555555,
                           32'haaaaaaaa), 0, none});
    rows.push_back('{op_of(rau_pkg::KIND_MUL, 6, -10, -15, 9), 0, none});
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (rows[i]) send_op(rows[i].op, rows[i].known, rows[i].res);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ((i * 5) / RANDOM_ITEMS)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 76; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 76; end
        3: begin send_idle_pct = 12; stall_pct = 12; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      // hold off until the queue drains
      if (i == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      send_op(rand_op(), 0, none);
    end
    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
